// ===== rtl/b64esc_pkg.sv =====
// b64esc_pkg: shared types, character codes and lookup functions for the
// base64 escape encoder. No dependencies.
`timescale 1ns / 1ps

package b64esc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_for_input;
      logic       string_done;
   } rsp_item_type;

   localparam logic [7:0] RUN_OPEN_CHAR  = 8'h2B;   // '+'
   localparam logic [7:0] RUN_CLOSE_CHAR = 8'h2D;   // '-'

   // bytes of the current 3-byte group already taken
   localparam logic [1:0] GRP_EMPTY = 2'd0;
   localparam logic [1:0] GRP_ONE   = 2'd1;
   localparam logic [1:0] GRP_TWO   = 2'd2;

   function automatic logic is_safe(input logic [7:0] b);
      logic r;
      case (b) inside
         [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]: r = 1'b1;
         8'h27, 8'h28, 8'h29, 8'h2C, 8'h2E, 8'h20, 8'h5F, 8'h2D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // base64 alphabet with ',' in place of '/'
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] r;
      case (v) inside
         [6'd0:6'd25]:  r = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: r = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: r = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         r = 8'h2B;
         default:       r = 8'h2C;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/run_base64_escape_encoder_core.sv =====
// Base64 escape encoder: safe bytes pass through, runs of other bytes are
// framed by '+' ... '-' (no '-' at string end), base64-encoded without padding.
// Depends on b64esc_pkg.
//
// Usage:
//   req channel carries one string byte per transfer with end_of_string on
//   the final byte. rsp channel carries 1 to 3 characters per input byte;
//   last_for_input marks the final character of a byte and string_done the
//   final character of the string.
//   A byte taken from req waits in the input register until the burst
//   register is free, is then encoded into the burst register, and its
//   first character is offered on rsp from then on.
//   Throughput: one byte per cycle while each byte gives a single character
//   and rsp does not stall; otherwise the single-character rsp port
//   draining the burst register sets the pace.
//   The input register is refilled in the same cycle the burst register
//   takes its content, so a new byte is accepted while characters still wait.
//   Reset (synchronous, active high) empties both registers and returns the
//   encoder to outside-of-run state. A stalled rsp holds its character; once
//   the input register is also full, req_stall rises.
`timescale 1ns / 1ps

module run_base64_escape_encoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  b64esc_pkg::req_item_type    req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output b64esc_pkg::rsp_item_type    rsp_data
);

   // input register
   logic                     in_valid_ff, in_valid_in;
   b64esc_pkg::req_item_type in_item_ff;

   // encoder state
   logic       run_ff, run_in;
   logic [1:0] grp_ff, grp_in;
   logic [7:0] prev_ff, prev_in;

   // burst register: characters of one byte, drained from entry 0
   logic       burst_valid_ff, burst_valid_in;
   logic [7:0] chars_ff [3];
   logic [1:0] rem_ff;
   logic       done_ff;

   logic [7:0] list [3];
   logic [1:0] n;
   logic [1:0] eff_grp;
   logic [7:0] b;
   logic       rsp_fire, burst_free, load;

   assign rsp_fire   = burst_valid_ff && !rsp_stall;
   assign burst_free = !burst_valid_ff || (rsp_fire && rem_ff == 2'd1);
   assign load       = in_valid_ff && burst_free;
   assign req_stall  = in_valid_ff && !load;

   assign rsp_valid               = burst_valid_ff;
   assign rsp_data.out_char       = chars_ff[0];
   assign rsp_data.last_for_input = (rem_ff == 2'd1);
   assign rsp_data.string_done    = (rem_ff == 2'd1) && done_ff;

   assign b = in_item_ff.in_byte;

   // encode one byte into up to three characters
   always_comb begin
      list[0] = '0;
      list[1] = '0;
      list[2] = '0;
      n       = 2'd0;
      run_in  = run_ff;
      grp_in  = grp_ff;
      prev_in = prev_ff;
      eff_grp = (run_ff && grp_ff != 2'd3) ? grp_ff : b64esc_pkg::GRP_EMPTY;
      if (b64esc_pkg::is_safe(b)) begin
         if (run_ff) begin
            if (eff_grp == b64esc_pkg::GRP_ONE) begin
               list[n] = b64esc_pkg::enc_char({prev_ff[1:0], 4'b0000});
               n = n + 2'd1;
            end else if (eff_grp == b64esc_pkg::GRP_TWO) begin
               list[n] = b64esc_pkg::enc_char({prev_ff[3:0], 2'b00});
               n = n + 2'd1;
            end
            list[n] = b64esc_pkg::RUN_CLOSE_CHAR;
            n = n + 2'd1;
         end
         list[n] = b;
         n = n + 2'd1;
         run_in = 1'b0;
         grp_in = b64esc_pkg::GRP_EMPTY;
      end else begin
         if (!run_ff) begin
            list[n] = b64esc_pkg::RUN_OPEN_CHAR;
            n = n + 2'd1;
         end
         case (eff_grp)
            b64esc_pkg::GRP_ONE: begin
               list[n] = b64esc_pkg::enc_char({prev_ff[1:0], b[7:4]});
               n = n + 2'd1;
               grp_in = b64esc_pkg::GRP_TWO;
            end
            b64esc_pkg::GRP_TWO: begin
               list[n] = b64esc_pkg::enc_char({prev_ff[3:0], b[7:6]});
               n = n + 2'd1;
               list[n] = b64esc_pkg::enc_char(b[5:0]);
               n = n + 2'd1;
               grp_in = b64esc_pkg::GRP_EMPTY;
            end
            default: begin
               list[n] = b64esc_pkg::enc_char(b[7:2]);
               n = n + 2'd1;
               grp_in = b64esc_pkg::GRP_ONE;
            end
         endcase
         run_in  = 1'b1;
         prev_in = b;
         // end of string flushes the partial group, no closing dash
         if (in_item_ff.end_of_string) begin
            if (grp_in == b64esc_pkg::GRP_ONE) begin
               list[n] = b64esc_pkg::enc_char({b[1:0], 4'b0000});
               n = n + 2'd1;
            end else if (grp_in == b64esc_pkg::GRP_TWO) begin
               list[n] = b64esc_pkg::enc_char({b[3:0], 2'b00});
               n = n + 2'd1;
            end
         end
      end
      if (in_item_ff.end_of_string) begin
         run_in  = 1'b0;
         grp_in  = b64esc_pkg::GRP_EMPTY;
         prev_in = '0;
      end
   end

   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !load);

   always_comb begin
      if (load) begin
         burst_valid_in = 1'b1;
      end else if (rsp_fire && rem_ff == 2'd1) begin
         burst_valid_in = 1'b0;
      end else begin
         burst_valid_in = burst_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         burst_valid_ff <= 1'b0;
         run_ff         <= 1'b0;
         grp_ff         <= b64esc_pkg::GRP_EMPTY;
         prev_ff        <= '0;
         rem_ff         <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= in_valid_in;
         end
         burst_valid_ff <= burst_valid_in;
         if (load) begin
            run_ff  <= run_in;
            grp_ff  <= grp_in;
            prev_ff <= prev_in;
            rem_ff  <= n;
         end else if (rsp_fire) begin
            rem_ff <= rem_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
      if (load) begin
         chars_ff[0] <= list[0];
         chars_ff[1] <= list[1];
         chars_ff[2] <= list[2];
         done_ff     <= in_item_ff.end_of_string;
      end else if (rsp_fire) begin
         chars_ff[0] <= chars_ff[1];
         chars_ff[1] <= chars_ff[2];
      end
   end

endmodule

// ===== rtl/b64esc_checker.sv =====
// b64esc_checker: port-level assertions for the base64 escape encoder,
// bound to run_base64_escape_encoder_core. Depends on b64esc_pkg.
`timescale 1ns / 1ps

module b64esc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input b64esc_pkg::req_item_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input b64esc_pkg::rsp_item_type rsp_data
);

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a string end is always the end of its byte's characters
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_done |-> rsp_data.last_for_input)
      else $error("string_done without last_for_input");

   // the characters of one byte follow without gaps
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_for_input |=> rsp_valid)
      else $error("gap inside a byte's characters");

   // a stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transfer changed");

endmodule

bind run_base64_escape_encoder_core b64esc_checker u_b64esc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
